@@ rtl/smf_pkg.sv @@
// Shared types and constants for the sliding window median filter.
`default_nettype none

package smf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int HALF_W   = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Flags one cell hands along the chain.
    typedef struct packed {
        logic le;    // holds a live sample that is not above the new one
        logic dpre;  // the expiring sample sits in this cell or below
        logic below; // the updated content of this cell stays under the new sample
    } cell_flags_t;

endpackage

`default_nettype wire

@@ rtl/smf_cell.sv @@
// One cell of the sorted window: holds one sample and its age.
`default_nettype none

module smf_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5,
    parameter int AW    = 5
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        step,
    input  wire                        clear,
    input  wire                        first,
    input  wire                        full,
    input  wire                        empty_after,
    input  wire [AW-1:0]               oldest_age,
    input  wire [CW-1:0]               fill_next,
    input  smf_pkg::sample_t           sample,
    input  smf_pkg::sample_t           prev_value,
    input  wire [AW-1:0]               prev_age,
    input  smf_pkg::cell_flags_t       prev_flags,
    input  smf_pkg::sample_t           next_value,
    input  wire [AW-1:0]               next_age,
    input  smf_pkg::cell_flags_t       next_flags,
    output smf_pkg::sample_t           value,
    output logic [AW-1:0]              age,
    output smf_pkg::cell_flags_t       flags,
    output smf_pkg::sample_t           value_out_next
);

    smf_pkg::sample_t value_reg;
    smf_pkg::sample_t value_next;
    logic [AW-1:0]    age_reg;
    logic [AW-1:0]    age_next;
    logic             valid_reg;
    logic             valid_next;
    logic             live;
    logic             del;
    logic             ins_here;

    always_comb
    begin
        live        = valid_reg & ~first;
        del         = full & live & (age_reg == oldest_age);
        flags.le    = live & ~(value_reg > sample);
        flags.dpre  = prev_flags.dpre | del;
        flags.below = flags.dpre ? next_flags.le : flags.le;
        ins_here    = ~flags.below & prev_flags.below;

        if (flags.below)
        begin
            value_next = flags.dpre ? next_value : value_reg;
            age_next   = (flags.dpre ? next_age : age_reg) + AW'(1);
        end
        else if (ins_here)
        begin
            value_next = sample;
            age_next   = '0;
        end
        else
        begin
            value_next = prev_flags.dpre ? value_reg : prev_value;
            age_next   = (prev_flags.dpre ? age_reg : prev_age) + AW'(1);
        end

        valid_next = ~empty_after & (CW'(INDEX) < fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value          = value_reg;
    assign age            = age_reg;
    assign value_out_next = value_next;

endmodule

`default_nettype wire

@@ rtl/sliding_window_median_filter.sv @@
// Top level of the running median filter: cell chain, fill control, output register.
`default_nettype none

// Running median over an odd window of 2*half_window+1 signed Q16.16 samples.
// Throughput is one sample per clock unless the output stalls: the window is kept
// as a chain of cells sorted by value, and each accepted sample retires the oldest
// entry and is inserted in order in a single pass through the chain, each cell
// looking only at its two neighbors. The result of an input transaction appears
// in the output register in the cycle after it; s_tready drops only while a
// result waits and m_tready is low. No result comes until the window is full;
// s_tuser high starts a new signal, s_tlast marks the final sample and empties
// the window afterwards. A half_window of 0 acts as 1, values above
// (MAX_WINDOW-1)/2 are clamped, and writing the register empties the window.
module sliding_window_median_filter #(
    parameter int MAX_WINDOW = 31
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration
    input  wire                          cfg_we,
    input  wire [smf_pkg::HALF_W-1:0]    cfg_wdata,   // half_window
    // sample stream in
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [smf_pkg::SAMPLE_W-1:0]  s_tdata,     // [31:0] sample
    input  wire                          s_tuser,     // [0] first_sample
    input  wire                          s_tlast,     // last_sample
    // median stream out
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [smf_pkg::SAMPLE_W-1:0] m_tdata,     // [31:0] median
    output logic                         m_tlast      // last_median
);

    localparam int CW   = $clog2(MAX_WINDOW + 1);   // fill count width
    localparam int AW   = $clog2(MAX_WINDOW);       // age and cell index width
    localparam int HMAX = (MAX_WINDOW - 1) / 2;
    localparam int EW   = (CW > smf_pkg::HALF_W) ? CW : smf_pkg::HALF_W;

    // configuration and fill state
    logic [smf_pkg::HALF_W-1:0] half_reg;
    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              fill_next;

    logic [EW-1:0]              half_ext;
    logic [EW-1:0]              half_sel;
    logic [CW-1:0]              half_eff;
    logic [CW-1:0]              win_len;
    logic [AW-1:0]              oldest_age;
    logic [CW-1:0]              fill_eff;
    logic [CW-1:0]              fill_ins;
    logic                       full;
    logic                       produce;
    logic                       accept;

    // output register
    logic                       m_tvalid_reg;
    logic                       m_tvalid_next;
    smf_pkg::sample_t           m_tdata_reg;
    logic                       m_tlast_reg;

    // chain wiring
    smf_pkg::sample_t           cell_value [MAX_WINDOW];
    logic [AW-1:0]              cell_age   [MAX_WINDOW];
    smf_pkg::cell_flags_t       cell_flags [MAX_WINDOW];
    smf_pkg::sample_t           cell_vnext [MAX_WINDOW];

    // effective window length after clamping
    always_comb
    begin
        half_ext = EW'(half_reg);
        if (half_ext == '0)
        begin
            half_sel = EW'(1);
        end
        else if (half_ext > EW'(HMAX))
        begin
            half_sel = EW'(HMAX);
        end
        else
        begin
            half_sel = half_ext;
        end
        half_eff   = CW'(half_sel);
        win_len    = CW'({half_eff, 1'b1});
        oldest_age = AW'({half_eff, 1'b0});
    end

    // a first flag empties the window before this sample goes in, a last flag after it
    always_comb
    begin
        accept   = s_tvalid & s_tready;
        fill_eff = s_tuser ? '0 : fill_reg;
        full     = (fill_eff == win_len);
        fill_ins = full ? fill_eff : fill_eff + CW'(1);
        produce  = (fill_ins == win_len);

        if (s_tlast)
        begin
            fill_next = '0;
        end
        else
        begin
            fill_next = fill_ins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= smf_pkg::HALF_W'(1);
            fill_reg <= '0;
        end
        else if (cfg_we)
        begin
            half_reg <= cfg_wdata;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    // sorted chain of cells
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        smf_pkg::sample_t     prev_value;
        logic [AW-1:0]        prev_age;
        smf_pkg::cell_flags_t prev_flags;
        smf_pkg::sample_t     next_value;
        logic [AW-1:0]        next_age;
        smf_pkg::cell_flags_t next_flags;

        if (i == 0)
        begin : g_head
            assign prev_value = '0;
            assign prev_age   = '0;
            assign prev_flags = '{le: 1'b0, dpre: 1'b0, below: 1'b1};
        end
        else
        begin : g_link_prev
            assign prev_value = cell_value[i-1];
            assign prev_age   = cell_age[i-1];
            assign prev_flags = cell_flags[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_tail
            assign next_value = '0;
            assign next_age   = '0;
            assign next_flags = '{le: 1'b0, dpre: 1'b0, below: 1'b0};
        end
        else
        begin : g_link_next
            assign next_value = cell_value[i+1];
            assign next_age   = cell_age[i+1];
            assign next_flags = cell_flags[i+1];
        end

        smf_cell #(
            .INDEX (i),
            .CW    (CW),
            .AW    (AW)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (accept),
            .clear          (cfg_we),
            .first          (s_tuser),
            .full           (full),
            .empty_after    (s_tlast),
            .oldest_age     (oldest_age),
            .fill_next      (fill_ins),
            .sample         (s_tdata),
            .prev_value     (prev_value),
            .prev_age       (prev_age),
            .prev_flags     (prev_flags),
            .next_value     (next_value),
            .next_age       (next_age),
            .next_flags     (next_flags),
            .value          (cell_value[i]),
            .age            (cell_age[i]),
            .flags          (cell_flags[i]),
            .value_out_next (cell_vnext[i])
        );
    end

    // output register; a new sample is taken while the held result drains
    assign s_tready = ~m_tvalid_reg | m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        if (accept && produce)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // median is the entry of rank half_eff, the clamped half window, in the updated chain
    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            m_tdata_reg <= cell_vnext[half_eff[AW-1:0]];
            m_tlast_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // the fill count never runs past the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_len)
        else $error("fill count above window length");

    // a register write leaves an empty window
    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (fill_reg == '0))
        else $error("window not emptied by register write");

    // no new sample while a result is stuck
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted over a stalled result");

    // a result appears only after an accepted sample
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(m_tvalid_reg) && m_tvalid_reg) |-> $past(accept))
        else $error("result without input transaction");
`endif

endmodule

`default_nettype wire

@@ tb/median_check.sv @@
// Checker for the median filter: predicts medians from the input stream and compares them.
module median_check (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire [smf_pkg::HALF_W-1:0]   cfg_wdata,
    input  wire                         s_tvalid,
    input  wire                         s_tready,
    input  wire [smf_pkg::SAMPLE_W-1:0] s_tdata,
    input  wire                         s_tuser,
    input  wire                         s_tlast,
    input  wire                         m_tvalid,
    input  wire                         m_tready,
    input  wire [smf_pkg::SAMPLE_W-1:0] m_tdata,
    input  wire                         m_tlast,
    output int                          mismatches,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 31;

    typedef struct packed {
        smf_pkg::sample_t median;
        logic             last;
    } median_item_t;

    median_item_t                 median_queue[$];
    smf_pkg::sample_t             ring [DEPTH];
    int                           fill;
    int                           oldest;
    logic [smf_pkg::HALF_W-1:0]   half_reg;

    // Effective window length: zero acts as one, clamped so it fits DEPTH.
    function automatic int span_len(input logic [smf_pkg::HALF_W-1:0] h);
        int hh;
        hh = h;
        if (hh == 0)
            hh = 1;
        if (hh > (DEPTH - 1) / 2)
            hh = (DEPTH - 1) / 2;
        return 2 * hh + 1;
    endfunction

    // Sort a copy of the live slots and take the middle one.
    function automatic smf_pkg::sample_t median_of_window(input int w);
        smf_pkg::sample_t sorted [DEPTH];
        smf_pkg::sample_t key;
        int i;
        int j;
        for (i = 0; i < w; i++)
            sorted[i] = ring[i];
        for (i = 1; i < w; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[(w - 1) / 2];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int w;
        median_item_t item;
        if (!rst_n)
        begin
            median_queue.delete();
            fill = 0;
            oldest = 0;
            half_reg = 1;
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_reg = cfg_wdata;
                fill = 0;
                oldest = 0;
            end
            if (s_tvalid && s_tready)
            begin
                w = span_len(half_reg);
                if (s_tuser)
                begin
                    fill = 0;
                    oldest = 0;
                end
                if (fill < w)
                begin
                    ring[fill] = s_tdata;
                    fill++;
                    oldest = 0;
                end
                else
                begin
                    if (oldest >= w)
                        oldest = 0;
                    ring[oldest] = s_tdata;
                    oldest++;
                    if (oldest >= w)
                        oldest = 0;
                end
                if (fill >= w)
                begin
                    item.median = median_of_window(w);
                    item.last = s_tlast;
                    median_queue.push_back(item);
                end
                if (s_tlast)
                begin
                    fill = 0;
                    oldest = 0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (median_queue.size() == 0)
                    report_mismatch("unexpected median", m_tdata, '0);
                else
                begin
                    item = median_queue.pop_front();
                    if (m_tdata !== item.median)
                        report_mismatch("median", m_tdata, item.median);
                    if (m_tlast !== item.last)
                        report_mismatch("last_median", m_tlast, item.last);
                end
            end
            outstanding = median_queue.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the median filter testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transaction on any channel before the run is called dead.
    localparam int WATCHDOG_LIMIT = 5000;
    // Long receiver hold-off used to back the filter up into its input.
    localparam int HOLD_CYCLES = 300;
    // Quiet cycles after the last median, to cover an item still in flight
    // that produced no median.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 100;

    localparam smf_pkg::sample_t S_MIN  = smf_pkg::sample_t'(32'h8000_0000);
    localparam smf_pkg::sample_t S_MAX  = smf_pkg::sample_t'(32'h7fff_ffff);
    localparam smf_pkg::sample_t S_ZERO = smf_pkg::sample_t'(32'h0000_0000);
    localparam smf_pkg::sample_t S_NEG1 = smf_pkg::sample_t'(32'hffff_ffff);

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [smf_pkg::HALF_W-1:0]   cfg_wdata;   // half_window
    logic                         s_tvalid;
    logic                         s_tready;
    logic [smf_pkg::SAMPLE_W-1:0] s_tdata;     // [31:0] sample
    logic                         s_tuser;     // [0] first_sample
    logic                         s_tlast;     // last_sample
    logic                         m_tvalid;
    logic                         m_tready;
    logic [smf_pkg::SAMPLE_W-1:0] m_tdata;     // [31:0] median
    logic                         m_tlast;     // last_median

    int mismatches;
    int outstanding;

    // Traffic shaping, changed per phase by the stimulus.
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;

    int cur_len;      // window length the filter should be using now
    int sent;         // sample transactions in the current phase
    int idle_run;     // watchdog count

    sliding_window_median_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    median_check checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls per phase; on request one long hold-off, counted
    // here, while the sender keeps offering so the filter backs up.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any transaction or register write restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", idle_run);
            $display("status: fail");
            $finish;
        end
    end

    // One sample transaction, with random idle cycles ahead of it. tvalid
    // stays high across back-to-back transactions.
    task automatic send_sample(input smf_pkg::sample_t value, input logic first,
                               input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Stop offering and wait until every predicted median has come out.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Register write; only called with the filter drained and settled.
    task automatic write_half(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[smf_pkg::HALF_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_len = (value == 0) ? 3 : 2 * value + 1;
    endtask

    task automatic drain_and_settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mix of full-range values, extremes and a narrow band that makes ties common.
    function automatic smf_pkg::sample_t random_sample();
        case ($urandom_range(9))
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3, 4: return smf_pkg::sample_t'($signed($urandom_range(15)) - 8);
            default: return smf_pkg::sample_t'($urandom);
        endcase
    endfunction

    // One signal: mostly long enough to fill the window and closed by last,
    // sometimes short, sometimes unmarked, now and then restarted midway.
    task automatic send_signal();
        int n;
        int i;
        logic first;
        logic last;
        if ($urandom_range(5) == 0)
            n = $urandom_range(cur_len - 1, 1);
        else
            n = cur_len + $urandom_range(24);
        for (i = 0; i < n; i++)
        begin
            if (i == 0)
                first = ($urandom_range(9) != 0);
            else
                first = ($urandom_range(49) == 0);
            last = (i == n - 1) && ($urandom_range(9) != 0);
            send_sample(random_sample(), first, last);
        end
    endtask

    initial
    begin
        int phase;
        int half_value;
        bit paused;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        s_tlast        <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        idle_run       = 0;
        cur_len        = 3;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset window of three.
        // Extremes fill the window, then a restart midway through a signal.
        send_sample(S_MIN, 1'b1, 1'b0);
        send_sample(S_MAX, 1'b0, 1'b0);
        send_sample(S_ZERO, 1'b0, 1'b0);
        send_sample(S_NEG1, 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(5), 1'b1, 1'b0);
        send_sample(smf_pkg::sample_t'(6), 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(7), 1'b0, 1'b1);
        // One-sample signal: first and last together.
        send_sample(smf_pkg::sample_t'(3), 1'b1, 1'b1);
        // Short signal started only by the preceding last.
        send_sample(smf_pkg::sample_t'(1), 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(2), 1'b0, 1'b1);
        // Ties at the negative extreme.
        send_sample(S_MAX, 1'b0, 1'b0);
        send_sample(S_MIN, 1'b0, 1'b0);
        send_sample(S_MIN, 1'b0, 1'b1);
        drain_and_settle();

        // Zero half window behaves as one.
        write_half(0);
        send_sample(smf_pkg::sample_t'(10), 1'b1, 1'b0);
        send_sample(smf_pkg::sample_t'(-10), 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(-10), 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(20), 1'b0, 1'b1);
        // Partially filled window, then a register write must empty it.
        send_sample(smf_pkg::sample_t'(100), 1'b1, 1'b0);
        send_sample(smf_pkg::sample_t'(200), 1'b0, 1'b0);
        drain_and_settle();
        write_half(2);
        send_sample(smf_pkg::sample_t'(-3), 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(9), 1'b0, 1'b0);
        send_sample(smf_pkg::sample_t'(4), 1'b0, 1'b0);
        send_sample(S_MAX, 1'b0, 1'b0);
        send_sample(S_MIN, 1'b0, 1'b1);
        drain_and_settle();

        // Random phases, each with its own traffic pattern and window.
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  half_value = 1;
                end
                1:
                begin
                    send_idle_pct = 54; recv_stall_pct = 0;  half_value = 15;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 54; half_value = 0;
                end
                3:
                begin
                    send_idle_pct = 31; recv_stall_pct = 31; half_value = 7;
                end
                default:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    half_value = $urandom_range(14, 2);
                end
            endcase
            write_half(half_value);
            // Back the filter up once, with no stalls otherwise.
            if (phase == 0)
                hold_request = 1'b1;
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                send_signal();
                // Sender pause midway until all medians are out.
                if (!paused && sent >= PHASE_ITEMS / 2)
                begin
                    wait_results();
                    paused = 1'b1;
                end
            end
            drain_and_settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
